@@ design/utf8sd_pkg.sv @@
// shared types, constants and validity checks for the utf-8 stream decoder
package utf8sd_pkg;

    localparam int CP_W = 31;

    localparam logic [CP_W-1:0] C_REPLACEMENT = 31'h0000FFFD;
    localparam logic [CP_W-1:0] C_SURR_LO     = 31'h0000D800;
    localparam logic [CP_W-1:0] C_SURR_HI     = 31'h0000DFFF;
    localparam logic [CP_W-1:0] C_NONCHAR_FE  = 31'h0000FFFE;
    localparam logic [CP_W-1:0] C_NONCHAR_FF  = 31'h0000FFFF;

    localparam logic [CP_W-1:0] C_MIN_LEN2 = 31'h00000080;
    localparam logic [CP_W-1:0] C_MIN_LEN3 = 31'h00000800;
    localparam logic [CP_W-1:0] C_MIN_LEN4 = 31'h00010000;
    localparam logic [CP_W-1:0] C_MIN_LEN5 = 31'h00200000;
    localparam logic [CP_W-1:0] C_MIN_LEN6 = 31'h04000000;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            end_of_text;
    } t_result;

    // smallest legal value for a sequence of the given length
    function automatic logic [CP_W-1:0] min_for_length(input logic [2:0] len);
        logic [CP_W-1:0] m;
        case (len)
            3'd2:    m = C_MIN_LEN2;
            3'd3:    m = C_MIN_LEN3;
            3'd4:    m = C_MIN_LEN4;
            3'd5:    m = C_MIN_LEN5;
            3'd6:    m = C_MIN_LEN6;
            default: m = '0;
        endcase
        return m;
    endfunction

    // overlong, surrogate and fffe/ffff values become the replacement char
    function automatic logic [CP_W-1:0] check_value(input logic [CP_W-1:0] v,
                                                    input logic [2:0] len);
        logic bad;
        bad = (v < min_for_length(len))
           || ((v >= C_SURR_LO) && (v <= C_SURR_HI))
           || (v == C_NONCHAR_FE) || (v == C_NONCHAR_FF);
        return bad ? C_REPLACEMENT : v;
    endfunction

endpackage

@@ design/utf8_stream_decoder.sv @@
// utf-8 stream decoder top level: byte in, code points out
// an accepted byte passes the input register, then the result register, before its first result is output
// throughput: one byte per cycle while the output is not stalled; a byte that gives
//   two results (interrupted sequence) holds the decode stage while the second drains
// reset: synchronous active low, clears the input and result valids and the
//   sequence state (accumulator, bytes remaining, sequence length)
module utf8_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [30:0] o_code_point,
    output logic        o_end_of_text
);
    import utf8sd_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // sequence state
    logic [CP_W-1:0] r_acc, n_acc;
    logic [2:0]      r_rem, n_rem;
    logic [2:0]      r_len, n_len;

    // result register pair, slot 0 is the one shown on the output
    t_result    r_res0, r_res1, n_res0, n_res1;
    logic [1:0] r_res_cnt, n_res_cnt;

    logic pop;
    logic advance;
    logic take;

    // decode wires
    logic            is_zero;
    logic            is_cont;
    logic            mid_seq;
    logic            interrupted;
    logic            lead_ok;
    logic [4:0]      lead_mask;
    logic [2:0]      lead_len;
    logic            start_emit;
    logic [CP_W-1:0] start_cp;
    logic [CP_W-1:0] cont_acc;

    assign pop     = (r_res_cnt != 2'd0) && !i_stall;
    // the result pair is free for the byte in the input register
    assign advance = (r_res_cnt == 2'd0) || ((r_res_cnt == 2'd1) && pop);
    assign take    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;

    assign o_valid       = (r_res_cnt != 2'd0);
    assign o_code_point  = r_res0.code_point;
    assign o_end_of_text = r_res0.end_of_text;

    // lead byte class: mask of payload bits and total sequence length
    always_comb begin
        lead_ok   = 1'b1;
        lead_mask = 5'h00;
        lead_len  = 3'd0;
        if (r_in_byte[7:5] == 3'b110) begin
            lead_mask = 5'h1F; lead_len = 3'd2;
        end else if (r_in_byte[7:4] == 4'b1110) begin
            lead_mask = 5'h0F; lead_len = 3'd3;
        end else if (r_in_byte[7:3] == 5'b11110) begin
            lead_mask = 5'h07; lead_len = 3'd4;
        end else if (r_in_byte[7:2] == 6'b111110) begin
            lead_mask = 5'h03; lead_len = 3'd5;
        end else if (r_in_byte[7:1] == 7'b1111110) begin
            lead_mask = 5'h01; lead_len = 3'd6;
        end else begin
            lead_ok = 1'b0;
        end
    end

    assign is_zero     = (r_in_byte == 8'h00);
    assign is_cont     = (r_in_byte[7:6] == 2'b10);
    assign mid_seq     = (r_rem != 3'd0);
    assign interrupted = mid_seq && !is_cont;
    assign cont_acc    = {r_acc[CP_W-7:0], r_in_byte[5:0]};

    // ascii passes through; a stray continuation or fe/ff gives a replacement
    always_comb begin
        if (!r_in_byte[7]) begin
            start_emit = 1'b1;
            start_cp   = {{(CP_W-8){1'b0}}, r_in_byte};
        end else if (lead_ok) begin
            start_emit = 1'b0;
            start_cp   = C_REPLACEMENT;
        end else begin
            start_emit = 1'b1;
            start_cp   = C_REPLACEMENT;
        end
    end

    // next state and results for the byte in the input register
    always_comb begin
        n_acc     = r_acc;
        n_rem     = r_rem;
        n_len     = r_len;
        n_res0    = r_res0;
        n_res1    = r_res1;
        n_res_cnt = r_res_cnt;

        if (pop) begin
            // shift the second result forward
            n_res0    = r_res1;
            n_res_cnt = r_res_cnt - 2'd1;
        end

        if (take) begin
            n_res0    = '{code_point: start_cp, end_of_text: 1'b0};
            n_res1    = '{code_point: start_cp, end_of_text: 1'b0};
            n_res_cnt = 2'd0;
            if (is_zero) begin
                // end of text drops any partial sequence silently
                n_acc     = '0;
                n_rem     = 3'd0;
                n_len     = 3'd0;
                n_res0    = '{code_point: '0, end_of_text: 1'b1};
                n_res_cnt = 2'd1;
            end else if (mid_seq && is_cont) begin
                n_acc = cont_acc;
                n_rem = r_rem - 3'd1;
                if (r_rem == 3'd1) begin
                    n_res0    = '{code_point: check_value(cont_acc, r_len),
                                  end_of_text: 1'b0};
                    n_res_cnt = 2'd1;
                    n_acc     = '0;
                    n_len     = 3'd0;
                end
            end else begin
                // interrupted sequence reports first, then the byte restarts
                if (interrupted) begin
                    n_res0 = '{code_point: C_REPLACEMENT, end_of_text: 1'b0};
                end
                n_res_cnt = {1'b0, interrupted} + {1'b0, start_emit};
                if (r_in_byte[7] && lead_ok) begin
                    n_acc = {{(CP_W-5){1'b0}}, r_in_byte[4:0] & lead_mask};
                    n_len = lead_len;
                    n_rem = lead_len - 3'd1;
                end else begin
                    n_acc = '0;
                    n_len = 3'd0;
                    n_rem = 3'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_acc      <= '0;
            r_rem      <= 3'd0;
            r_len      <= 3'd0;
            r_res_cnt  <= 2'd0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            r_acc     <= n_acc;
            r_rem     <= n_rem;
            r_len     <= n_len;
            r_res_cnt <= n_res_cnt;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_data_byte;
        end
        r_res0 <= n_res0;
        r_res1 <= n_res1;
    end

endmodule
